### rtl/sdcs_pkg.sv
package sdcs_pkg;

  // Input kinds
  localparam logic [1:0] FuncLoad    = 2'd0;
  localparam logic [1:0] FuncRow     = 2'd1;
  localparam logic [1:0] FuncResolve = 2'd2;

  // Colors
  localparam logic [1:0] ColUnknown = 2'd0;
  localparam logic [1:0] ColBlue    = 2'd1;
  localparam logic [1:0] ColYellow  = 2'd2;
  localparam logic [1:0] ColOrange  = 2'd3;

  // Register indexes
  localparam logic [2:0] RegLeftWidth   = 3'd0;
  localparam logic [2:0] RegLeftHeight  = 3'd1;
  localparam logic [2:0] RegRightWidth  = 3'd2;
  localparam logic [2:0] RegRightHeight = 3'd3;
  localparam logic [2:0] RegScoreThr    = 3'd4;

  localparam int unsigned ScoreBits  = 12;
  localparam int unsigned NumClasses = 5;
  localparam int unsigned ClassSlot  = 12;
  localparam int unsigned LabelBits  = 3;

  // Model is 640 pixels: 128*640 = 5 << 14 and 64*640 = 5 << 13.
  // Scale by shift first, then by an exact reciprocal of 5 for 16-bit values.
  localparam int unsigned PosShift   = 14;
  localparam int unsigned SizeShift  = 13;
  localparam logic [16:0] Recip5     = 17'd52429;
  localparam int unsigned RecipShift = 18;

  // Expected height in Q16.8: 15.6 -> 3994, 198 * 65536 as the dividend
  localparam logic [23:0] HeightBias = 24'd3994;
  localparam logic [23:0] HeightNum  = 24'd12976128;
  localparam logic [23:0] Sat24      = 24'hFFFFFF;
  localparam int unsigned DivSteps   = 24;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [12:0] left_width;
    logic [12:0] left_height;
    logic [12:0] right_width;
    logic [12:0] right_height;
    logic [11:0] score_thr;
  } sdcs_cfg_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic                 side;
    logic [16:0]          point_x;
    logic [16:0]          point_y;
    logic [15:0]          depth;
    logic [15:0]          box_cx;
    logic [15:0]          box_cy;
    logic [15:0]          box_w;
    logic [15:0]          box_h;
    logic [LabelBits-1:0] label;
    logic [ScoreBits-1:0] prob;
  } sdcs_cmd_t;

  function automatic logic [1:0] label_to_color(input logic [LabelBits-1:0] label);
    logic [1:0] col;
    case (label)
      3'd0:         col = ColBlue;
      3'd2, 3'd3:   col = ColOrange;
      3'd4:         col = ColYellow;
      default:      col = ColUnknown;
    endcase
    return col;
  endfunction

endpackage

### rtl/sdcs_queue.sv
module sdcs_queue
  import sdcs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sdcs_cmd_t cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output sdcs_cmd_t head_o,
  output logic      valid_o
);

  localparam int unsigned PtrBits = $clog2(QueueDepth);

  sdcs_cmd_t            mem_q [QueueDepth];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrBits:0]     count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (PtrBits+1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### rtl/sdcs_front.sv
module sdcs_front
  import sdcs_pkg::*;
(
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,
  input  logic [11:0]  score_thr_i,
  input  logic         q_full_i,
  output logic         push_o,
  output sdcs_cmd_t    cmd_o
);

  logic [1:0]           func;
  logic [11:0]          box_score;
  logic [59:0]          class_scores;
  logic [ScoreBits-1:0] max_p;
  logic [LabelBits-1:0] max_lab;
  logic                 keep;

  assign func         = s_axis_tuser[1:0];
  assign box_score    = s_axis_tdata[125:114];
  assign class_scores = s_axis_tdata[185:126];

  // First maximum over the class slots; all zero leaves class 0
  always_comb begin
    max_p   = '0;
    max_lab = '0;
    for (int j = 0; j < NumClasses; j++) begin
      if (class_scores[j*ClassSlot +: ScoreBits] > max_p) begin
        max_p   = class_scores[j*ClassSlot +: ScoreBits];
        max_lab = LabelBits'(j);
      end
    end
  end

  // Drop unknown kinds and rows at or below threshold before the queue
  always_comb begin
    case (func)
      FuncLoad, FuncResolve: keep = 1'b1;
      FuncRow:               keep = box_score[ScoreBits-1:0] > score_thr_i[ScoreBits-1:0];
      default:               keep = 1'b0;
    endcase
  end

  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i && keep;

  always_comb begin
    cmd_o.kind    = func;
    cmd_o.side    = s_axis_tuser[2];
    cmd_o.point_x = s_axis_tdata[16:0];
    cmd_o.point_y = s_axis_tdata[33:17];
    cmd_o.depth   = s_axis_tdata[49:34];
    cmd_o.box_cx  = s_axis_tdata[65:50];
    cmd_o.box_cy  = s_axis_tdata[81:66];
    cmd_o.box_w   = s_axis_tdata[97:82];
    cmd_o.box_h   = s_axis_tdata[113:98];
    cmd_o.label   = max_lab;
    cmd_o.prob    = max_p;
  end

endmodule

### rtl/sdcs_back.sv
module sdcs_back
  import sdcs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  sdcs_cfg_t    cfg_i,
  input  sdcs_cmd_t    head_i,
  input  logic         head_valid_i,
  output logic         pop_o,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDiv   = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StScale = 3'd3;
  localparam logic [2:0] StUpd   = 3'd4;

  logic [2:0]  state_q, state_d;
  sdcs_cmd_t   cmd_q;

  // Per-side search state
  logic [16:0]          query_col_q [2];
  logic [16:0]          query_row_q [2];
  logic [23:0]          exp_h_q     [2];
  logic [23:0]          best_diff_q [2];
  logic [LabelBits-1:0] best_label_q[2];
  logic [ScoreBits-1:0] best_prob_q [2];
  logic [1:0]           found_q;

  // Divider
  logic [15:0] rem_q;
  logic [23:0] quo_q;
  logic [4:0]  cnt_q;
  logic [16:0] trial;
  logic        trial_ok;
  logic [15:0] rem_next;
  logic [23:0] quo_next;

  // Box arithmetic
  logic signed [31:0] prod_x_q, prod_y_q;
  logic        [28:0] prod_w_q, prod_h_q;
  logic signed [14:0] box_x_q, box_y_q;
  logic        [13:0] box_w_q, box_h_q;

  logic [12:0]        cols, rows;
  logic signed [17:0] dx, dy;
  logic [31:0]        mag_x, mag_y;
  logic [32:0]        sc_x, sc_y, sc_w, sc_h;
  logic [13:0]        q_x, q_y;

  logic signed [15:0] sum_x, sum_y;
  logic signed [20:0] px_e, py_e, xl_e, xr_e, yt_e, yb_e;
  logic               hit;
  logic [23:0]        hq, diff;
  logic               take;

  // Output stage
  logic        out_valid_q;
  logic [1:0]  out_color_q;
  logic [11:0] out_score_q;
  logic        out_free;
  logic [1:0]  col_l, col_r, col_m;
  logic [11:0] sc_l, sc_r, sc_m;

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    pop_o = 1'b0;
    if (state_q == StIdle && head_valid_i) begin
      pop_o = (head_i.kind != FuncResolve) || out_free;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (pop_o) begin
          if (head_i.kind == FuncLoad && head_i.depth != '0) begin
            state_d = StDiv;
          end else if (head_i.kind == FuncRow) begin
            state_d = StMul;
          end
        end
      end
      StDiv:   if (cnt_q == 5'(DivSteps - 1)) state_d = StIdle;
      StMul:   state_d = StScale;
      StScale: state_d = StUpd;
      StUpd:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // One quotient bit a cycle
  always_comb begin
    trial    = {rem_q, quo_q[23]};
    trial_ok = trial >= {1'b0, cmd_q.depth};
    rem_next = trial_ok ? 16'(trial - {1'b0, cmd_q.depth}) : trial[15:0];
    quo_next = {quo_q[22:0], trial_ok};
  end

  always_comb begin
    cols = cmd_q.side ? cfg_i.right_width  : cfg_i.left_width;
    rows = cmd_q.side ? cfg_i.right_height : cfg_i.left_height;
    dx   = $signed({1'b0, cmd_q.box_cx, 1'b0}) - $signed({2'b0, cmd_q.box_w});
    dy   = $signed({1'b0, cmd_q.box_cy, 1'b0}) - $signed({2'b0, cmd_q.box_h});
  end

  // Magnitude, shift, then divide by 5; sign goes back afterwards (truncate to zero)
  always_comb begin
    mag_x = prod_x_q[31] ? 32'(-prod_x_q) : prod_x_q;
    mag_y = prod_y_q[31] ? 32'(-prod_y_q) : prod_y_q;
    sc_x  = mag_x[PosShift +: 16] * Recip5;
    sc_y  = mag_y[PosShift +: 16] * Recip5;
    sc_w  = prod_w_q[SizeShift +: 16] * Recip5;
    sc_h  = prod_h_q[SizeShift +: 16] * Recip5;
    q_x   = sc_x[RecipShift +: 14];
    q_y   = sc_y[RecipShift +: 14];
  end

  always_comb begin
    sum_x = $signed({box_x_q[14], box_x_q}) + $signed({2'b0, box_w_q});
    sum_y = $signed({box_y_q[14], box_y_q}) + $signed({2'b0, box_h_q});
    px_e  = $signed({{4{query_col_q[cmd_q.side][16]}}, query_col_q[cmd_q.side]});
    py_e  = $signed({{4{query_row_q[cmd_q.side][16]}}, query_row_q[cmd_q.side]});
    xl_e  = $signed({{2{box_x_q[14]}}, box_x_q, 4'b0});
    yt_e  = $signed({{2{box_y_q[14]}}, box_y_q, 4'b0});
    xr_e  = $signed({sum_x[15], sum_x, 4'b0});
    yb_e  = $signed({sum_y[15], sum_y, 4'b0});
    hit   = (px_e > xl_e) && (px_e < xr_e) && (py_e > yt_e) && (py_e < yb_e);
    hq    = {2'b0, box_h_q, 8'b0};
    diff  = (hq > exp_h_q[cmd_q.side]) ? hq - exp_h_q[cmd_q.side]
                                       : exp_h_q[cmd_q.side] - hq;
    take  = hit && (!found_q[cmd_q.side] || diff < best_diff_q[cmd_q.side]);
  end

  // Merge: known beats unknown, higher score wins, right wins ties
  always_comb begin
    col_l = found_q[0] ? label_to_color(best_label_q[0]) : ColUnknown;
    col_r = found_q[1] ? label_to_color(best_label_q[1]) : ColUnknown;
    sc_l  = (col_l != ColUnknown) ? best_prob_q[0] : '0;
    sc_r  = (col_r != ColUnknown) ? best_prob_q[1] : '0;
    if (col_l != ColUnknown && (col_r == ColUnknown || sc_l > sc_r)) begin
      col_m = col_l;
      sc_m  = sc_l;
    end else begin
      col_m = col_r;
      sc_m  = sc_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      found_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      for (int s = 0; s < 2; s++) begin
        query_col_q[s]  <= '0;
        query_row_q[s]  <= '0;
        exp_h_q[s]      <= '0;
        best_diff_q[s]  <= '0;
        best_label_q[s] <= '0;
        best_prob_q[s]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (pop_o && head_i.kind == FuncResolve) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o && head_i.kind == FuncLoad) begin
        query_col_q[head_i.side] <= head_i.point_x;
        query_row_q[head_i.side] <= head_i.point_y;
        found_q[head_i.side]     <= 1'b0;
        if (head_i.depth == '0) begin
          exp_h_q[head_i.side] <= Sat24;
        end
      end
      if (state_q == StIdle) begin
        cnt_q <= '0;
      end else if (state_q == StDiv) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'(DivSteps - 1)) begin
          exp_h_q[cmd_q.side] <= HeightBias + quo_next;
        end
      end
      if (state_q == StUpd && take) begin
        found_q[cmd_q.side]      <= 1'b1;
        best_diff_q[cmd_q.side]  <= diff;
        best_label_q[cmd_q.side] <= cmd_q.label;
        best_prob_q[cmd_q.side]  <= cmd_q.prob;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i;
      rem_q <= '0;
      quo_q <= HeightNum;
    end else if (state_q == StDiv) begin
      rem_q <= rem_next;
      quo_q <= quo_next;
    end
    if (state_q == StMul) begin
      prod_x_q <= 32'(dx * $signed({1'b0, cols}));
      prod_y_q <= 32'(dy * $signed({1'b0, rows}));
      prod_w_q <= cmd_q.box_w * cols;
      prod_h_q <= cmd_q.box_h * rows;
    end
    if (state_q == StScale) begin
      box_x_q <= prod_x_q[31] ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
      box_y_q <= prod_y_q[31] ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
      box_w_q <= sc_w[RecipShift +: 14];
      box_h_q <= sc_h[RecipShift +: 14];
    end
    if (pop_o && head_i.kind == FuncResolve) begin
      out_color_q <= col_m;
      out_score_q <= sc_m;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b0, out_score_q, out_color_q};

endmodule

### rtl/stereo_detection_color_select.sv
// Result path: with nothing ahead of it, a resolve item is written into the queue; at the head,
//   with the execute side idle and the output free, it is popped into the register that drives m_axis_tvalid.
// Throughput: the input takes an item every cycle while the four-entry queue has room;
//   the execute side ends a resolve or zero-depth load at its pop, steps a passing row
//   through multiply, scale and compare, and runs a nonzero-depth load through the one-bit-a-cycle divider.
// Rows at or below threshold and unknown kinds are dropped at the input and cost nothing.
// Reset: asynchronous, active low; clears queue, search state and registers to defaults.
module stereo_detection_color_select
  import sdcs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_x, point_y, point_depth, box_cx, box_cy, box_w, box_h, box_score, class_scores
  input  logic [191:0] s_axis_tdata,
  // func, side
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cone_color, cone_score
  output logic [15:0]  m_axis_tdata
);

  sdcs_cfg_t  cfg_q;
  logic [2:0] reg_idx;
  logic       cfg_wr;
  logic       q_full, q_push, q_pop, q_valid;
  sdcs_cmd_t  q_in, q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_width   <= 13'd1280;
      cfg_q.left_height  <= 13'd720;
      cfg_q.right_width  <= 13'd1280;
      cfg_q.right_height <= 13'd720;
      cfg_q.score_thr    <= 12'd2048;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegLeftWidth:   cfg_q.left_width   <= pwdata[12:0];
        RegLeftHeight:  cfg_q.left_height  <= pwdata[12:0];
        RegRightWidth:  cfg_q.right_width  <= pwdata[12:0];
        RegRightHeight: cfg_q.right_height <= pwdata[12:0];
        RegScoreThr:    cfg_q.score_thr    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegLeftWidth:   prdata = {19'b0, cfg_q.left_width};
      RegLeftHeight:  prdata = {19'b0, cfg_q.left_height};
      RegRightWidth:  prdata = {19'b0, cfg_q.right_width};
      RegRightHeight: prdata = {19'b0, cfg_q.right_height};
      RegScoreThr:    prdata = {20'b0, cfg_q.score_thr};
      default:        prdata = '0;
    endcase
  end

  sdcs_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .score_thr_i   (cfg_q.score_thr),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .cmd_o         (q_in)
  );

  sdcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .valid_o (q_valid)
  );

  sdcs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (q_head),
    .head_valid_i  (q_valid),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sdcs_pkg::*;

  localparam int unsigned RandomItems  = 1150;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned SettleCycles = 150;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned MaxReports   = 10;

  localparam longint PosDiv       = 81920;     // 128 * model size
  localparam longint SizeDiv      = 40960;     // 64 * model size
  localparam longint HeightBiasQ8 = 3994;      // 15.6 in Q.8
  localparam longint GainQ16      = 12976128;  // 198 << 16
  localparam logic [23:0] DiffSat = 24'hFFFFFF;

  // func code 3 carries no meaning; the block drops it
  localparam logic [1:0] FuncNone = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic               side;
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic [15:0]        depth;
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [11:0]        score;
    logic [59:0]        cls;
  } det_item_t;

  typedef struct packed {
    logic [1:0]  color;
    logic [11:0] score;
  } cone_t;

  typedef struct packed {
    logic      is_cfg;
    logic [2:0] reg_idx;
    logic [12:0] reg_val;
    det_item_t item;
    logic      typed;
    cone_t     want;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // point_x, point_y, point_depth, box_cx, box_cy, box_w, box_h, box_score, class_scores
  logic [191:0] s_axis_tdata = '0;
  // func, side
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // cone_color, cone_score
  logic [15:0]  m_axis_tdata;

  // Shadow of the block's search state and registers
  logic signed [16:0] query_x [2];
  logic signed [16:0] query_y [2];
  logic [23:0] target_h [2];
  logic [23:0] closest_diff [2];
  logic [2:0]  closest_label [2];
  logic [11:0] closest_prob [2];
  logic        box_seen [2];
  logic [12:0] frame_w [2];
  logic [12:0] frame_h [2];
  logic [11:0] score_thr;

  cone_t    expected_cones [$];
  dir_row_t dir_rows [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int stall_cycles = 0;
  int items_sent = 0;

  stereo_detection_color_select dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic det_item_t make_item(input logic [1:0] func, input logic side,
                                          input logic [16:0] px, input logic [16:0] py,
                                          input logic [15:0] depth, input logic [15:0] cx,
                                          input logic [15:0] cy, input logic [15:0] w,
                                          input logic [15:0] h, input logic [11:0] score,
                                          input logic [59:0] cls);
    det_item_t it;
    it.func  = func;
    it.side  = side;
    it.px    = px;
    it.py    = py;
    it.depth = depth;
    it.cx    = cx;
    it.cy    = cy;
    it.w     = w;
    it.h     = h;
    it.score = score;
    it.cls   = cls;
    return it;
  endfunction

  function automatic logic [59:0] classes5(input logic [11:0] p0, input logic [11:0] p1,
                                           input logic [11:0] p2, input logic [11:0] p3,
                                           input logic [11:0] p4);
    return {p4, p3, p2, p1, p0};
  endfunction

  function automatic logic [15:0] clamp16(input longint v);
    logic [15:0] r;
    if (v < 0) r = 16'd0;
    else if (v > 65535) r = 16'hFFFF;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic [1:0] color_of(input logic [2:0] label);
    logic [1:0] col;
    case (label)
      3'd0:       col = ColBlue;
      3'd2, 3'd3: col = ColOrange;
      3'd4:       col = ColYellow;
      default:    col = ColUnknown;
    endcase
    return col;
  endfunction

  // Map a model-space center and size to the frame: left edge truncated toward
  // zero, extent floored.
  task automatic decode_span(input logic [15:0] center, input logic [15:0] size,
                             input logic [12:0] scale, output longint lo, output longint ext);
    longint c, sz, k;
    c  = center;
    sz = size;
    k  = scale;
    lo  = ((2 * c - sz) * k) / PosDiv;
    ext = (sz * k) / SizeDiv;
  endtask

  task automatic predict_cone(input det_item_t it, input logic typed, input cone_t want);
    longint x, y, bw, bh, px, py, hq, th, diff, dep, quot;
    logic [11:0] p, maxp, sl, sr;
    logic [2:0]  lab;
    logic [1:0]  cl, cr;
    cone_t       res;
    int          s, j;
    s = it.side;
    case (it.func)
      FuncLoad: begin
        query_x[s] = it.px;
        query_y[s] = it.py;
        dep = it.depth;
        if (dep == 0) begin
          target_h[s] = DiffSat;
        end else begin
          quot = HeightBiasQ8 + GainQ16 / dep;
          target_h[s] = quot[23:0];
        end
        box_seen[s] = 1'b0;
      end
      FuncRow: begin
        if (it.score > score_thr) begin
          decode_span(it.cx, it.w, frame_w[s], x, bw);
          decode_span(it.cy, it.h, frame_h[s], y, bh);
          px = query_x[s];
          py = query_y[s];
          if (px > x * 16 && px < (x + bw) * 16 && py > y * 16 && py < (y + bh) * 16) begin
            maxp = '0;
            lab  = '0;
            for (j = 0; j < NumClasses; j++) begin
              p = it.cls[j*ClassSlot +: ScoreBits];
              if (p > maxp) begin
                maxp = p;
                lab  = j[2:0];
              end
            end
            hq = bh * 256;
            th = target_h[s];
            diff = (hq > th) ? hq - th : th - hq;
            if (diff > DiffSat) diff = DiffSat;
            if (!box_seen[s] || diff < closest_diff[s]) begin
              box_seen[s]      = 1'b1;
              closest_diff[s]  = diff[23:0];
              closest_label[s] = lab;
              closest_prob[s]  = maxp;
            end
          end
        end
      end
      FuncResolve: begin
        cl = box_seen[0] ? color_of(closest_label[0]) : ColUnknown;
        cr = box_seen[1] ? color_of(closest_label[1]) : ColUnknown;
        sl = (cl != ColUnknown) ? closest_prob[0] : 12'd0;
        sr = (cr != ColUnknown) ? closest_prob[1] : 12'd0;
        if (cl != ColUnknown && cr == ColUnknown) begin
          res.color = cl;
          res.score = sl;
        end else if (cl == ColUnknown && cr != ColUnknown) begin
          res.color = cr;
          res.score = sr;
        end else if (cl != ColUnknown) begin
          // right side takes a tie
          res.color = (sl > sr) ? cl : cr;
          res.score = (sl > sr) ? sl : sr;
        end else begin
          res.color = ColUnknown;
          res.score = 12'd0;
        end
        expected_cones.push_back(typed ? want : res);
      end
      default: ;
    endcase
  endtask

  task automatic send_detection(input det_item_t it, input logic typed, input cone_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, it.cls, it.score, it.h, it.w, it.cy, it.cx, it.depth,
                      it.py, it.px};
    s_axis_tuser  <= {it.side, it.func};
    do @(posedge clk_i); while (!s_axis_tready);
    if (it.func != FuncNone && !(it.func == FuncRow && it.score <= score_thr))
      items_sent++;
    predict_cone(it, typed, want);
  endtask

  // Drain: every result back, then let queued rows and loads finish.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_cones.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {19'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegLeftWidth:   frame_w[0] = val;
      RegLeftHeight:  frame_h[0] = val;
      RegRightWidth:  frame_w[1] = val;
      RegRightHeight: frame_h[1] = val;
      RegScoreThr:    score_thr  = val[11:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_frame(input logic [12:0] lw, input logic [12:0] lh,
                             input logic [12:0] rw, input logic [12:0] rh,
                             input logic [12:0] thr);
    write_reg(RegLeftWidth, lw);
    write_reg(RegLeftHeight, lh);
    write_reg(RegRightWidth, rw);
    write_reg(RegRightHeight, rh);
    write_reg(RegScoreThr, thr);
  endtask

  task automatic add_item(input det_item_t it);
    dir_row_t r;
    r = '0;
    r.item = it;
    dir_rows.push_back(r);
  endtask

  task automatic add_typed(input det_item_t it, input logic [1:0] color,
                           input logic [11:0] score);
    dir_row_t r;
    r = '0;
    r.item = it;
    r.typed = 1'b1;
    r.want.color = color;
    r.want.score = score;
    dir_rows.push_back(r);
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [12:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    dir_rows.push_back(r);
  endtask

  function automatic logic [59:0] gen_classes();
    logic [59:0] v;
    logic [11:0] top;
    int a, b, j;
    v = '0;
    case ($urandom_range(4))
      0: v = '0;
      1: v = {$urandom, $urandom};
      2: begin
        for (j = 0; j < 5; j++) v[j*12 +: 12] = $urandom_range(200);
        a = $urandom_range(4);
        v[a*12 +: 12] = $urandom_range(4095, 201);
      end
      3: begin
        // one or two random slots share the maximum
        top = $urandom_range(4095, 1);
        for (j = 0; j < 5; j++) v[j*12 +: 12] = $urandom_range(top - 1);
        a = $urandom_range(4);
        b = $urandom_range(4);
        v[a*12 +: 12] = top;
        v[b*12 +: 12] = top;
      end
      default: for (j = 0; j < 5; j++) v[j*12 +: 12] = $urandom_range(15);
    endcase
    return v;
  endfunction

  function automatic logic [11:0] pass_score();
    logic [11:0] sc;
    if (score_thr < 12'hFFF && $urandom_range(9) != 0) sc = $urandom_range(4095, score_thr + 1);
    else sc = $urandom_range(4095);
    return sc;
  endfunction

  // For one or both sides a query (at times skipped) and a burst of rows built around a box
  // that holds the pixel, then mostly a resolve, at times sent twice.
  task automatic run_scene();
    det_item_t   it, prev;
    logic [15:0] tcx, tcy, tw, th, hh;
    longint      x, y, bw, bh, px, py, den, dv;
    int          first, sides, k, s, n, i, r;
    cone_t       none;
    none  = '0;
    first = $urandom_range(1);
    sides = ($urandom_range(3) == 0) ? 1 : 2;
    for (k = 0; k < sides; k++) begin
      s  = first ^ k;
      tw = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(12800, 640));
      th = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(12800, 640));
      tcx = $urandom_range(40960);
      tcy = $urandom_range(40960);
      decode_span(tcx, tw, frame_w[s], x, bw);
      decode_span(tcy, th, frame_h[s], y, bh);
      px = (bw > 0) ? x * 16 + 1 + $urandom_range(bw * 16 - 2) : longint'($signed(17'($urandom)));
      py = (bh > 0) ? y * 16 + 1 + $urandom_range(bh * 16 - 2) : longint'($signed(17'($urandom)));
      if (px < -65536 || px > 65535) px = $signed(17'($urandom));
      if (py < -65536 || py > 65535) py = $signed(17'($urandom));
      den = bh * 256 - HeightBiasQ8;
      case ($urandom_range(5))
        0:       dv = 0;
        1, 2:    dv = $urandom_range(65535);
        default: dv = (den > 0) ? GainQ16 / den + $urandom_range(4) : $urandom_range(65535);
      endcase
      // now and then skip the load so rows hit a stale query
      if ($urandom_range(9) != 0)
        send_detection(make_item(FuncLoad, s[0], px[16:0], py[16:0], clamp16(dv),
                                 $urandom, $urandom, $urandom, $urandom, $urandom,
                                 {$urandom, $urandom}), 1'b0, none);
      n = $urandom_range(8, 1);
      prev = make_item(FuncRow, s[0], 0, 0, 0, tcx, tcy, tw, th, pass_score(), gen_classes());
      for (i = 0; i < n; i++) begin
        r = $urandom_range(9);
        if (r < 7) begin
          hh = (r % 2 == 0) ? th : clamp16(longint'(th) + 64 * (int'($urandom_range(6)) - 3));
          it = make_item(FuncRow, s[0], $urandom, $urandom, $urandom,
                         clamp16(longint'(tcx) + int'($urandom_range(640)) - 320),
                         clamp16(longint'(tcy) + int'($urandom_range(640)) - 320),
                         clamp16(longint'(tw) + int'($urandom_range(1280)) - 640),
                         hh, pass_score(), gen_classes());
        end else if (r == 7) begin
          it = make_item(FuncRow, s[0], $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, {$urandom, $urandom});
        end else if (r == 8) begin
          it = make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, {$urandom, $urandom});
          if (it.func == FuncResolve) it.func = FuncNone;
        end else begin
          it = prev;  // repeat gives an equal-distance tie
        end
        send_detection(it, 1'b0, none);
        if (it.func == FuncRow) prev = it;
      end
    end
    r = $urandom_range(9);
    if (r != 0) begin
      it = make_item(FuncResolve, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, {$urandom, $urandom});
      send_detection(it, 1'b0, none);
      if (r == 1) send_detection(it, 1'b0, none);
    end
  endtask

  // Result check and receiver stalls
  always @(posedge clk_i) begin
    cone_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_cones.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("unexpected cone result: color %0d score %0d",
                   m_axis_tdata[1:0], m_axis_tdata[13:2]);
      end else begin
        want = expected_cones.pop_front();
        if (m_axis_tdata[1:0] !== want.color || m_axis_tdata[13:2] !== want.score) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("cone mismatch: expected color %0d score %0d, got color %0d score %0d",
                     want.color, want.score, m_axis_tdata[1:0], m_axis_tdata[13:2]);
        end
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == StallLimit) begin
        $display("no handshake for %0d cycles, %0d results outstanding",
                 StallLimit, expected_cones.size());
        $display("** stereo_detection_color_select: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int s, p, target;
    for (s = 0; s < 2; s++) begin
      query_x[s] = '0;
      query_y[s] = '0;
      target_h[s] = '0;
      closest_diff[s] = '0;
      closest_label[s] = '0;
      closest_prob[s] = '0;
      box_seen[s] = 1'b0;
      frame_w[s] = 13'd1280;
      frame_h[s] = 13'd720;
    end
    score_thr = 12'd2048;

    // Box B decodes to x 80..120, y 88..110 at 1280x720 and holds pixel (100,100).
    add_typed(make_item(FuncResolve, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), ColUnknown, 12'd0);
    // row against the reset query at pixel 0,0
    add_item(make_item(FuncRow, 0, 0, 0, 0, 64, 64, 640, 640, 4095, classes5(7, 0, 0, 0, 0)));
    add_item(make_item(FuncResolve, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // zero depth saturates the expected height
    add_item(make_item(FuncLoad, 0, 1600, 1600, 0, 0, 0, 0, 0, 0, 0));
    add_item(make_item(FuncRow, 0, 0, 0, 0, 3200, 5689, 1280, 1280, 2048,
                       classes5(0, 0, 100, 0, 0)));
    add_item(make_item(FuncRow, 0, 0, 0, 0, 3200, 5689, 1280, 1280, 2049, '0));
    add_item(make_item(FuncRow, 0, 0, 0, 0, 3200, 5689, 1280, 1280, 4095,
                       classes5(0, 0, 0, 0, 900)));
    add_item(make_item(FuncLoad, 1, 1600, 1600, 256, 0, 0, 0, 0, 0, 0));
    add_item(make_item(FuncRow, 1, 0, 0, 0, 3200, 5689, 1280, 1280, 3000,
                       classes5(5, 5, 1, 9, 1)));
    add_item(make_item(FuncResolve, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_item(make_item(FuncLoad, 0, 1600, 1600, 256, 0, 0, 0, 0, 0, 0));
    add_item(make_item(FuncRow, 0, 0, 0, 0, 3200, 5689, 1280, 1280, 3000,
                       classes5(0, 9, 0, 0, 0)));
    add_item(make_item(FuncResolve, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_item(make_item(FuncLoad, 0, 1600, 1600, 256, 0, 0, 0, 0, 0, 0));
    add_item(make_item(FuncRow, 0, 0, 0, 0, 3200, 5689, 1280, 1280, 3000,
                       classes5(0, 0, 0, 0, 9)));
    // equal scores on both sides: right wins
    add_item(make_item(FuncResolve, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_item(make_item(FuncNone, 1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    add_item(make_item(FuncLoad, 1, -65536, 65535, 65535, 0, 0, 0, 0, 0, 0));
    add_item(make_item(FuncRow, 1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    add_item(make_item(FuncLoad, 0, 65535, -65536, 1, 0, 0, 0, 0, 0, 0));
    add_item(make_item(FuncRow, 0, 0, 0, 0, 0, 0, 0, 0, 4095, '0));
    add_item(make_item(FuncResolve, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // zero frame width: no box can hold the pixel
    add_cfg(RegScoreThr, 13'd0);
    add_cfg(RegLeftWidth, 13'd0);
    add_item(make_item(FuncLoad, 0, 1600, 1600, 256, 0, 0, 0, 0, 0, 0));
    add_item(make_item(FuncRow, 0, 0, 0, 0, 3200, 5689, 1280, 1280, 1,
                       classes5(9, 0, 0, 0, 0)));
    add_item(make_item(FuncResolve, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cfg(RegScoreThr, 13'd4095);
    add_cfg(RegLeftWidth, 13'd1280);
    add_item(make_item(FuncRow, 0, 0, 0, 0, 3200, 5689, 1280, 1280, 4095,
                       classes5(9, 0, 0, 0, 0)));
    add_item(make_item(FuncResolve, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    send_idle_pct = 20;
    recv_idle_pct = 81;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_detection(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    items_sent = 0;
    for (p = 0; p < NumPhases; p++) begin
      if (p < 2) begin
        send_idle_pct = 20;
        recv_idle_pct = 81;
      end else if (p < 4) begin
        send_idle_pct = 81;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      case (p)
        0: write_frame(13'd1280, 13'd720, 13'd1280, 13'd720, 13'd2048);
        1: write_frame(13'd4096, 13'd4096, 13'd1, 13'd1, 13'd0);
        2: write_frame(13'd640, 13'd640, 13'd8191, 13'd0, 13'd4094);
        default: write_frame($urandom_range(4096, 1), $urandom_range(4096, 1),
                             $urandom_range(4096, 1), $urandom_range(4096, 1),
                             $urandom_range(4000));
      endcase
      target = (p + 1) * RandomItems / NumPhases;
      while (items_sent < target) run_scene();
    end

    settle();
    if (fail_count == 0 && expected_cones.size() == 0)
      $display("** stereo_detection_color_select: PASSED **");
    else
      $display("** stereo_detection_color_select: FAILED **");
    $finish;
  end

endmodule

### filelist.f
rtl/sdcs_pkg.sv
rtl/sdcs_queue.sv
rtl/sdcs_front.sv
rtl/sdcs_back.sv
rtl/stereo_detection_color_select.sv
test/testbench.sv
